### rtl/cte_pkg.sv
// Package: types, constants and curve helpers for the tension envelope.
`timescale 1ns / 1ps
package cte_pkg;

  localparam int unsigned SineTableDepth  = 256;
  localparam logic [15:0] DefaultDuration = 16'd15000;
  localparam logic [15:0] MinDuration     = 16'd100;
  localparam logic [15:0] MaxDuration     = 16'd60000;
  localparam logic [16:0] OneQ16          = 17'd65536;
  localparam logic [16:0] HoldBase        = 17'd58982;
  localparam logic [16:0] HoldLow         = 17'd52429;
  localparam logic [16:0] RelBase         = 17'd13107;
  localparam logic [16:0] RelSpan         = 17'd52429;
  localparam logic [16:0] RestBase        = 17'd6554;
  localparam logic [16:0] RestHigh        = 17'd13107;
  localparam logic [15:0] TenthQ16        = 16'd6554;
  localparam logic [15:0] BreatheReset    = 16'd13107;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SET   = 2'd1,
    REQ_TRIG  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_OVR_ACT  = 2'd1,
    CFG_OVR_VAL  = 2'd2,
    CFG_BREATHE  = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    PH_BUILD   = 2'd0,
    PH_HOLD    = 2'd1,
    PH_RELEASE = 2'd2,
    PH_REST    = 2'd3
  } phase_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  phase_select;
    logic [15:0] duration_ms;
  } in_t;

  typedef struct packed {
    logic [15:0] tension;
    logic [16:0] tempo_multiplier;
    logic [15:0] complexity_scale;
    logic [1:0]  phase;
    logic [15:0] progress;
  } out_t;

  // Quarter wave polynomial, x in Q0.15
  function automatic logic [15:0] quarter_wave(input logic [31:0] x);
    logic [31:0] x2, t, t3;
    x2 = (x * x) >> 15;
    t  = (32'd2320 * x2) >> 15;
    t3 = (x2 * (32'd21024 - t)) >> 15;
    return 16'((x * (32'd51472 - t3)) >> 15);
  endfunction

  // Signed Q1.15 sine table entry k of a table of 2^aw entries
  function automatic logic signed [16:0] sine_entry(input int unsigned k,
                                                    input int unsigned aw);
    int unsigned u, quad;
    logic [31:0] x;
    logic [15:0] v;
    u    = 4 * k;
    quad = u >> aw;
    x    = 32'(((u & ((32'd1 << aw) - 32'd1)) << 15) >> aw);
    v    = quad[0] ? quarter_wave(32'd32768 - x) : quarter_wave(x);
    return (quad >= 2) ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

endpackage

### rtl/cte_div.sv
// Bit-serial restoring divider: elapsed * 2^16 / duration, one quotient bit per cycle.
`timescale 1ns / 1ps
module cte_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [15:0] quo_o
);
  import cte_pkg::*;

  logic [16:0] rem_q, rem_d;
  logic [31:0] num_q, num_d;
  logic [15:0] quo_q, quo_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [17:0] trial;

  always_comb begin
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[31]} - {2'b00, den_i};
    if (start_i) begin
      rem_d  = '0;
      num_d  = {num_i, 16'h0000};
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[30:0], 1'b0};
      if (!trial[17]) begin
        rem_d = trial[16:0];
        quo_d = {quo_q[14:0], 1'b1};
      end else begin
        rem_d = {rem_q[15:0], num_q[31]};
        quo_d = {quo_q[14:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

### rtl/cyclic_tension_envelope.sv
// Top level: cyclic four-phase tension envelope with serial progress divider.
`timescale 1ns / 1ps
// One transaction at a time. After an input is accepted, the state is loaded,
// the divider is started, the bit-serial progress divider runs (one quotient
// bit per cycle over a 32-bit dividend), the quotient is captured, the sine
// table is read, two registered multiply steps follow and the curve value is
// stored. Input stall is high from acceptance until the result has been taken,
// so a new item is not accepted before the last result is taken; the result is
// held until taken. SINE_TABLE_DEPTH must be a power of two.
module cyclic_tension_envelope #(
  parameter int unsigned SINE_TABLE_DEPTH = cte_pkg::SineTableDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cte_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cte_pkg::out_t   out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [15:0]     cfg_data_i
);
  import cte_pkg::*;

  localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_LOOK, S_MUL1, S_MUL2, S_DONE
  } state_e;

  state_e      state_q;
  logic        enable_q, ovr_act_q;
  logic [15:0] ovr_val_q, breathe_q;
  logic [1:0]  phase_q;
  logic [15:0] elapsed_q, duration_q, itens_q;
  logic [1:0]  req_q;
  logic [16:0] p_q;
  logic        full_q;
  logic signed [16:0] sine_q;
  logic [31:0] m1_q;
  logic        out_valid_q;
  logic [15:0] progress_q;

  logic        div_start, div_done;
  logic [15:0] div_quo;
  logic [15:0] dur_eff;
  logic [15:0] dur_clamp;
  logic [AW-1:0] idx;
  logic [16:0] mag;
  logic [16:0] curve_v;
  logic [15:0] tens;
  logic        accept;
  logic signed [16:0] sine_rom [SINE_TABLE_DEPTH];

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE) || out_valid_q;
  assign cfg_ready_o = 1'b1;
  assign dur_eff     = (duration_q == 16'd0) ? DefaultDuration : duration_q;
  assign dur_clamp   = (in_data_i.duration_ms < MinDuration) ? MinDuration :
                       (in_data_i.duration_ms > MaxDuration) ? MaxDuration :
                       in_data_i.duration_ms;
  assign div_start   = (state_q == S_IDLE) && accept;

  // Constant sine table
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k, AW);
  end

  // Divider start is registered so that the loaded state is visible to it
  logic div_go_q;
  cte_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_go_q),
    .num_i  (elapsed_q),
    .den_i  (dur_eff),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_comb begin
    if (phase_q == PH_HOLD) idx = AW'((32'(p_q) * SINE_TABLE_DEPTH) >> 16);
    else                    idx = AW'((32'(p_q) * SINE_TABLE_DEPTH) >> 17);
  end

  assign mag = sine_q[16] ? 17'(-sine_q) : 17'(sine_q);

  // Final curve value from the registered product
  always_comb begin
    logic [17:0] v;
    logic [16:0] b;
    v = '0;
    b = '0;
    case (phase_q)
      PH_BUILD: v = 18'(m1_q);
      PH_HOLD: begin
        if (breathe_q == 16'd0) v = 18'(HoldBase);
        else begin
          b = 17'(m1_q);
          if (sine_q[16]) v = (18'(HoldBase) < 18'(b) + 18'(HoldLow)) ?
                               18'(HoldLow) : 18'(HoldBase) - 18'(b);
          else begin
            v = 18'(HoldBase) + 18'(b);
            if (v > 18'(OneQ16)) v = 18'(OneQ16);
          end
        end
      end
      PH_RELEASE: v = 18'(RelBase) + 18'(m1_q >> 16);
      PH_REST: begin
        b = 17'(m1_q >> 15);
        if (sine_q[16]) v = (18'(b) > 18'(RestBase)) ? 18'd0 : 18'(RestBase) - 18'(b);
        else begin
          v = 18'(RestBase) + 18'(b);
          if (v > 18'(RestHigh)) v = 18'(RestHigh);
        end
      end
      default: v = '0;
    endcase
    curve_v = (v > 18'd65535) ? 17'd65535 : 17'(v);
  end

  always_comb begin
    if (ovr_act_q)      tens = ovr_val_q;
    else if (!enable_q) tens = '0;
    else                tens = itens_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      enable_q    <= 1'b1;
      ovr_act_q   <= 1'b0;
      ovr_val_q   <= '0;
      breathe_q   <= BreatheReset;
      phase_q     <= PH_BUILD;
      elapsed_q   <= '0;
      duration_q  <= DefaultDuration;
      itens_q     <= '0;
      out_valid_q <= 1'b0;
      div_go_q    <= 1'b0;
      req_q       <= REQ_TICK;
      p_q         <= '0;
      full_q      <= 1'b0;
      sine_q      <= '0;
      m1_q        <= '0;
      progress_q  <= '0;
    end else begin
      div_go_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ENABLE:  enable_q  <= cfg_data_i[0];
          CFG_OVR_ACT: ovr_act_q <= cfg_data_i[0];
          CFG_OVR_VAL: ovr_val_q <= cfg_data_i;
          CFG_BREATHE: breathe_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (div_start) begin
          req_q <= in_data_i.req_type;
          case (in_data_i.req_type)
            REQ_TICK: if (elapsed_q != 16'hFFFF) elapsed_q <= elapsed_q + 16'd1;
            REQ_SET: begin
              phase_q    <= in_data_i.phase_select;
              duration_q <= dur_clamp;
              elapsed_q  <= '0;
            end
            REQ_TRIG: begin
              phase_q    <= PH_BUILD;
              duration_q <= (duration_q == 16'd0) ? DefaultDuration : duration_q;
              elapsed_q  <= '0;
            end
            default: ;
          endcase
          div_go_q <= 1'b1;
          state_q  <= S_DIV;
        end
        S_DIV: if (div_done) begin
          full_q  <= (elapsed_q >= dur_eff);
          p_q     <= (elapsed_q >= dur_eff) ? OneQ16 : {1'b0, div_quo};
          state_q <= S_LOOK;
        end
        S_LOOK: begin
          sine_q  <= sine_rom[idx];
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          case (phase_q)
            PH_BUILD:   m1_q <= 32'((34'(p_q) * 34'(p_q)) >> 16);
            PH_HOLD:    m1_q <= 32'(mag) * 32'(breathe_q);
            PH_RELEASE: m1_q <= 32'((64'(OneQ16 - p_q) * 64'(OneQ16 - p_q)) >> 16);
            default:    m1_q <= 32'(mag) * 32'(TenthQ16);
          endcase
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          case (phase_q)
            PH_BUILD: m1_q <= m1_q;
            PH_HOLD:  m1_q <= 32'((45'(m1_q) * 45'(TenthQ16)) >> 31);
            PH_RELEASE: m1_q <= 32'((64'(OneQ16) - 64'(m1_q)) * 64'(RelSpan));
            default:  m1_q <= m1_q;
          endcase
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (enable_q && req_q != REQ_NONE) begin
            itens_q <= curve_v[15:0];
            if (full_q) begin
              phase_q   <= phase_q + 2'd1;
              elapsed_q <= '0;
            end
          end
          out_valid_q <= 1'b1;
          progress_q  <= full_q ? 16'hFFFF : p_q[15:0];
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o                 = out_valid_q;
  assign out_data_o.tension          = tens;
  assign out_data_o.tempo_multiplier = OneQ16 + 17'(tens >> 1);
  assign out_data_o.complexity_scale = 16'd32768 + (tens >> 1);
  assign out_data_o.phase            = phase_q;
  assign out_data_o.progress         = progress_q;
endmodule

### rtl/cte_checker.sv
// Port-level checker for the tension envelope, bound to the top level.
`timescale 1ns / 1ps
module cte_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input cte_pkg::out_t out_data_o
);
  import cte_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o.progress))
    else $error("result dropped while stalled");

  a_tempo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.tempo_multiplier ==
                    OneQ16 + 17'(out_data_o.tension >> 1))
    else $error("tempo mismatch");

  a_cplx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.complexity_scale[15])
    else $error("complexity below half");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");
endmodule

bind cyclic_tension_envelope cte_checker u_cte_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
